### rtl/dsh_pkg.sv
// dsh_pkg: shared types and constants for the diamond-square height map block
// used by dsh_hash and diamond_square_heightmap_top; no dependencies
package dsh_pkg;

	// grid geometry: cell (a, b) lives at address a * GRID_H + b
	localparam int GRID_W  = 64;
	localparam int GRID_H  = 64;
	localparam int CRD_W   = 6;
	localparam int ADDR_W  = 12;
	localparam int CELLS   = GRID_W * GRID_H;

	// configuration register indexes
	localparam logic [2:0] REG_INITIAL_STEP  = 3'd0;
	localparam logic [2:0] REG_RANDOMIZE     = 3'd1;
	localparam logic [2:0] REG_ISLAND        = 3'd2;
	localparam logic [2:0] REG_INVERT        = 3'd3;
	localparam logic [2:0] REG_SMOOTH_PASSES = 3'd4;

	// request kinds
	localparam logic KIND_GENERATE = 1'b0;
	localparam logic KIND_READ     = 1'b1;

	// noise hash constants
	localparam logic [31:0] HASH_ROW_MUL = 32'd57;
	localparam logic [31:0] HASH_MUL     = 32'd60493;
	localparam logic [31:0] HASH_ADD0    = 32'd19990303;
	localparam logic [31:0] HASH_ADD1    = 32'd1376312589;
	localparam logic [31:0] HASH_MASK    = 32'h7fffffff;
	localparam logic [31:0] HASH_SCALE   = 32'd255;

	localparam logic [6:0] RANGE_START = 7'd80;
	localparam logic [7:0] CENTRE_VAL  = 8'd128;
	localparam logic [7:0] HEIGHT_MAX  = 8'd255;

	// hash unit request and response
	typedef struct packed {
		logic             start;
		logic [CRD_W-1:0] x;
		logic [CRD_W-1:0] y;
		logic [9:0]       offset;
		logic [6:0]       divisor;
	} dsh_hash_req_t;

	typedef struct packed {
		logic       busy;
		logic [7:0] noise;
		logic [6:0] rem;
	} dsh_hash_rsp_t;

	typedef enum logic [3:0] {
		H_IDLE, H_M0, H_MIX, H_M1, H_M2, H_ADD, H_M3, H_ADD2, H_M4, H_DIV
	} dsh_hstate_t;

	typedef enum logic [4:0] {
		S_IDLE, S_FILL, S_SEED, S_SEED_WAIT, S_LVL, S_CELL, S_GATHER, S_PUT,
		S_SM_PASS, S_SM_CELL, S_SM_GATHER, S_SM_WR, S_COPY_RD, S_COPY_WR,
		S_READ, S_READ_WAIT, S_RESP
	} dsh_state_t;

endpackage

### rtl/dsh_ram.sv
// dsh_ram: generic single-write, single-read memory with registered read data
// no dependencies
module dsh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/dsh_hash.sv
// dsh_hash: iterative noise hash on one shared 32x32 multiplier, then an
// 8-step restoring remainder; depends on dsh_pkg
module dsh_hash import dsh_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  dsh_hash_req_t req,
	output dsh_hash_rsp_t rsp
);

	dsh_hstate_t      hst_q, hst_d;
	logic [CRD_W-1:0] x_q, y_q;
	logic [9:0]       off_q;
	logic [6:0]       div_q;
	logic [63:0]      prod_q;
	logic [31:0]      n_q, t_q;
	logic [7:0]       noise_q;
	logic [6:0]       rem_q;
	logic [2:0]       cnt_q;
	logic [31:0]      mul_a, mul_b;
	logic [63:0]      mul_p;
	logic [31:0]      mix_n;
	logic [7:0]       rem_sh;

	// operand select for the shared multiplier
	always_comb begin
		mul_a = prod_q[31:0];
		mul_b = HASH_MUL;
		case (hst_q)
			H_M0: begin
				mul_a = 32'(off_q) + 32'(y_q);
				mul_b = HASH_ROW_MUL;
			end
			H_M1: begin
				mul_a = n_q;
				mul_b = n_q;
			end
			H_M2: begin
				mul_a = prod_q[31:0];
				mul_b = HASH_MUL;
			end
			H_M3: begin
				mul_a = n_q;
				mul_b = t_q;
			end
			H_M4: begin
				mul_a = t_q;
				mul_b = HASH_SCALE;
			end
			default: begin
				mul_a = prod_q[31:0];
				mul_b = HASH_MUL;
			end
		endcase
	end

	assign mul_p  = 64'(mul_a) * 64'(mul_b);
	assign mix_n  = 32'(x_q) + prod_q[31:0];
	assign rem_sh = {rem_q, noise_q[cnt_q]};

	// sequencer next state
	always_comb begin
		hst_d = hst_q;
		case (hst_q)
			H_IDLE: if (req.start) hst_d = H_M0;
			H_M0:   hst_d = H_MIX;
			H_MIX:  hst_d = H_M1;
			H_M1:   hst_d = H_M2;
			H_M2:   hst_d = H_ADD;
			H_ADD:  hst_d = H_M3;
			H_M3:   hst_d = H_ADD2;
			H_ADD2: hst_d = H_M4;
			H_M4:   hst_d = H_DIV;
			H_DIV:  if (cnt_q == 3'd0) hst_d = H_IDLE;
			default: hst_d = H_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hst_q <= H_IDLE;
		end else begin
			hst_q <= hst_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (hst_q)
			H_IDLE: begin
				x_q   <= req.x;
				y_q   <= req.y;
				off_q <= req.offset;
				div_q <= req.divisor;
			end
			H_MIX:  n_q <= (mix_n << 13) ^ mix_n;
			H_ADD:  t_q <= prod_q[31:0] + HASH_ADD0;
			H_ADD2: t_q <= (prod_q[31:0] + HASH_ADD1) & HASH_MASK;
			H_DIV: begin
				// one remainder bit per cycle, msb first
				if (rem_sh >= 8'(div_q)) begin
					rem_q <= 7'(rem_sh - 8'(div_q));
				end else begin
					rem_q <= rem_sh[6:0];
				end
				cnt_q <= cnt_q - 3'd1;
			end
			default: begin
			end
		endcase
		if (hst_q == H_M4) begin
			noise_q <= mul_p[38:31];
			rem_q   <= 7'd0;
			cnt_q   <= 3'd7;
		end
		if (hst_q == H_M0 || hst_q == H_M1 || hst_q == H_M2 || hst_q == H_M3) begin
			prod_q <= mul_p;
		end
	end

	assign rsp.busy  = (hst_q != H_IDLE);
	assign rsp.noise = noise_q;
	assign rsp.rem   = rem_q;

endmodule

### rtl/diamond_square_heightmap_top.sv
// diamond_square_heightmap_top: diamond-square height map generator with
// smoothing and cell read-back; depends on dsh_pkg, dsh_ram, dsh_hash
//
//  channel | signals                                       | direction
//  in      | in_valid, in_ready, kind, seed_offset, col, row | request in
//  out     | out_valid, out_ready, height_value, generate_done | result out
//  cfg     | cfg_write, cfg_index, cfg_data                  | register write
//
// a read request makes one grid memory read: S_READ, S_READ_WAIT, then S_RESP
// a generate fills all 4096 cells, hashes each seed, and for each square
// or diamond cell gathers four neighbours while the hash unit runs; then
// each smoothing pass averages 62*62 interior cells, one grid read per
// neighbour on the single grid read port; in_ready is low meanwhile
// a finished result waits in the output register; stalls hold it there
// reset clears control state only; grid contents are undefined until generated
module diamond_square_heightmap_top import dsh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [9:0] seed_offset,
	input  logic [5:0] col,
	input  logic [5:0] row,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] height_value,
	output logic       generate_done,
	input  logic       cfg_write,
	input  logic [2:0] cfg_index,
	input  logic [6:0] cfg_data
);

	dsh_state_t    state_q, state_d;
	dsh_hash_req_t hreq;
	dsh_hash_rsp_t hrsp;

	logic [6:0]  initial_step_q;
	logic        randomize_q, island_q, invert_q;
	logic [3:0]  smooth_passes_q;

	logic [7:0]  i_q, j_q;
	logic [6:0]  step_q, r_q;
	logic        phase_q, par_q;
	logic [3:0]  pass_q, nb_q;
	logic [10:0] acc_q;
	logic [11:0] fill_q;
	logic [9:0]  off_q;
	logic [5:0]  rd_col_q, rd_row_q;
	logic [7:0]  res_q;
	logic        gen_q;
	logic        out_valid_q, gdone_q;
	logic [7:0]  height_q;

	logic              grid_we, scr_we;
	logic [ADDR_W-1:0] grid_waddr, grid_raddr, scr_addr;
	logic [7:0]        grid_wdata, scr_wdata, grid_rdata, scr_rdata;

	logic [5:0]  s2;
	logic [7:0]  base, ip, jp;
	logic [5:0]  xm, xp, ym, yp, na, nb;
	logic [3:0]  nb_lim;
	logic        accept;
	logic [7:0]  seed_v, put_v;
	logic signed [8:0]  k;
	logic signed [12:0] t;
	logic        gather_done;

	dsh_ram #(.WIDTH(8), .DEPTH(CELLS)) u_grid (
		.clk(clk), .we(grid_we), .waddr(grid_waddr), .wdata(grid_wdata),
		.raddr(grid_raddr), .rdata(grid_rdata)
	);

	dsh_ram #(.WIDTH(8), .DEPTH(CELLS)) u_scratch (
		.clk(clk), .we(scr_we), .waddr(scr_addr), .wdata(scr_wdata),
		.raddr(scr_addr), .rdata(scr_rdata)
	);

	dsh_hash u_hash (.clk(clk), .arst_n(arst_n), .req(hreq), .rsp(hrsp));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_step_q  <= 7'd16;
			randomize_q     <= 1'b1;
			island_q        <= 1'b0;
			invert_q        <= 1'b0;
			smooth_passes_q <= 4'd6;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_INITIAL_STEP:  initial_step_q  <= cfg_data;
				REG_RANDOMIZE:     randomize_q     <= cfg_data[0];
				REG_ISLAND:        island_q        <= cfg_data[0];
				REG_INVERT:        invert_q        <= cfg_data[0];
				REG_SMOOTH_PASSES: smooth_passes_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// lattice geometry with wrap-around neighbours
	assign s2   = step_q[6:1];
	assign base = island_q ? {1'b0, step_q} : 8'd0;
	assign ip   = i_q + 8'(s2);
	assign jp   = j_q + 8'(s2);
	assign xm   = (i_q < 8'(s2)) ? 6'(8'(GRID_W) - 8'(s2)) : 6'(i_q - 8'(s2));
	assign xp   = (ip >= 8'(GRID_W)) ? 6'd0 : ip[5:0];
	assign ym   = (j_q < 8'(s2)) ? 6'(8'(GRID_H) - 8'(s2)) : 6'(j_q - 8'(s2));
	assign yp   = (jp >= 8'(GRID_H)) ? 6'd0 : jp[5:0];

	// neighbour coordinates for the gather sequences
	always_comb begin
		na = i_q[5:0];
		nb = j_q[5:0];
		if (state_q == S_SM_GATHER) begin
			case (nb_q)
				4'd0: begin na = i_q[5:0] - 6'd1; nb = j_q[5:0] - 6'd1; end
				4'd1: begin na = i_q[5:0] - 6'd1; nb = j_q[5:0];        end
				4'd2: begin na = i_q[5:0] - 6'd1; nb = j_q[5:0] + 6'd1; end
				4'd3: begin na = i_q[5:0];        nb = j_q[5:0] - 6'd1; end
				4'd4: begin na = i_q[5:0];        nb = j_q[5:0] + 6'd1; end
				4'd5: begin na = i_q[5:0] + 6'd1; nb = j_q[5:0] - 6'd1; end
				4'd6: begin na = i_q[5:0] + 6'd1; nb = j_q[5:0];        end
				default: begin na = i_q[5:0] + 6'd1; nb = j_q[5:0] + 6'd1; end
			endcase
		end else if (!phase_q) begin
			case (nb_q)
				4'd0:    begin na = xm; nb = ym; end
				4'd1:    begin na = xp; nb = ym; end
				4'd2:    begin na = xm; nb = yp; end
				default: begin na = xp; nb = yp; end
			endcase
		end else begin
			case (nb_q)
				4'd0:    begin na = i_q[5:0]; nb = ym;       end
				4'd1:    begin na = xm;       nb = j_q[5:0]; end
				4'd2:    begin na = i_q[5:0]; nb = yp;       end
				default: begin na = xp;       nb = j_q[5:0]; end
			endcase
		end
	end

	assign nb_lim      = (state_q == S_SM_GATHER) ? 4'd8 : 4'd4;
	assign gather_done = (nb_q == nb_lim);

	// seed value and displaced average
	always_comb begin
		seed_v = hrsp.noise;
		if (island_q && i_q == 8'(GRID_W / 2) && j_q == 8'(GRID_H / 2)) begin
			seed_v = CENTRE_VAL;
		end
		if (invert_q) begin
			seed_v = HEIGHT_MAX - seed_v;
		end
		k = $signed({2'b00, hrsp.rem}) - $signed({3'b000, r_q[6:1]});
		t = $signed({2'b00, acc_q}) + ($signed({{4{k[8]}}, k}) <<< 2);
		if (t < 0) begin
			put_v = 8'd0;
		end else if ((t >>> 2) > 13'sd255) begin
			put_v = HEIGHT_MAX;
		end else begin
			put_v = t[9:2];
		end
	end

	assign accept = in_valid && in_ready;

	// sequencer: next state and memory / hash controls
	always_comb begin
		state_d      = state_q;
		grid_we      = 1'b0;
		grid_waddr   = {i_q[5:0], j_q[5:0]};
		grid_wdata   = put_v;
		grid_raddr   = {na, nb};
		scr_we       = 1'b0;
		scr_addr     = {i_q[5:0], j_q[5:0]};
		scr_wdata    = acc_q[10:3];
		hreq.start   = 1'b0;
		hreq.x       = i_q[5:0];
		hreq.y       = j_q[5:0];
		hreq.offset  = off_q;
		hreq.divisor = r_q + 7'd1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (kind == KIND_READ) ? S_READ : S_FILL;
				end
			end
			S_FILL: begin
				grid_we    = 1'b1;
				grid_waddr = fill_q;
				grid_wdata = invert_q ? HEIGHT_MAX : 8'd0;
				if (fill_q == 12'(CELLS - 1)) state_d = S_SEED;
			end
			S_SEED: begin
				if (i_q >= 8'(GRID_W)) begin
					state_d = S_LVL;
				end else if (j_q < 8'(GRID_H)) begin
					hreq.start = 1'b1;
					state_d    = S_SEED_WAIT;
				end
			end
			S_SEED_WAIT: begin
				if (!hrsp.busy) begin
					grid_we    = 1'b1;
					grid_wdata = seed_v;
					state_d    = S_SEED;
				end
			end
			S_LVL: begin
				state_d = (step_q <= 7'd1) ? S_SM_PASS : S_CELL;
			end
			S_CELL: begin
				if (i_q >= 8'(GRID_W)) begin
					if (phase_q) state_d = S_LVL;
				end else if (j_q < 8'(GRID_H)) begin
					hreq.start = 1'b1;
					state_d    = S_GATHER;
				end
			end
			S_GATHER: begin
				if (gather_done) state_d = S_PUT;
			end
			S_PUT: begin
				if (!hrsp.busy) begin
					grid_we = 1'b1;
					state_d = S_CELL;
				end
			end
			S_SM_PASS: begin
				state_d = (pass_q == smooth_passes_q) ? S_RESP : S_SM_CELL;
			end
			S_SM_CELL: begin
				if (i_q == 8'(GRID_W - 1)) begin
					state_d = S_COPY_RD;
				end else if (j_q != 8'(GRID_H - 1)) begin
					state_d = S_SM_GATHER;
				end
			end
			S_SM_GATHER: begin
				if (gather_done) state_d = S_SM_WR;
			end
			S_SM_WR: begin
				scr_we  = 1'b1;
				state_d = S_SM_CELL;
			end
			S_COPY_RD: begin
				if (i_q == 8'(GRID_W - 1)) begin
					state_d = S_SM_PASS;
				end else if (j_q != 8'(GRID_H - 1)) begin
					state_d = S_COPY_WR;
				end
			end
			S_COPY_WR: begin
				grid_we    = 1'b1;
				grid_wdata = scr_rdata;
				state_d    = S_COPY_RD;
			end
			S_READ: begin
				grid_raddr = {rd_col_q, rd_row_q};
				state_d    = S_READ_WAIT;
			end
			S_READ_WAIT: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// loop counters and accumulators
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				off_q    <= seed_offset;
				rd_col_q <= col;
				rd_row_q <= row;
				gen_q    <= (kind == KIND_GENERATE);
				res_q    <= 8'd0;
				fill_q   <= 12'd0;
				step_q   <= (initial_step_q == 7'd0) ? 7'd1 : initial_step_q;
				r_q      <= randomize_q ? RANGE_START : 7'd0;
				i_q      <= island_q ? {1'b0, initial_step_q} : 8'd0;
				j_q      <= island_q ? {1'b0, initial_step_q} : 8'd0;
			end
			S_FILL: begin
				fill_q <= fill_q + 12'd1;
				// a zero step seeds from one when island is set
				if (island_q && initial_step_q == 7'd0) begin
					i_q <= 8'd1;
					j_q <= 8'd1;
				end
			end
			S_SEED: begin
				if (i_q < 8'(GRID_W) && j_q >= 8'(GRID_H)) begin
					i_q <= i_q + {1'b0, step_q};
					j_q <= base;
				end
			end
			S_SEED_WAIT: begin
				if (!hrsp.busy) j_q <= j_q + {1'b0, step_q};
			end
			S_LVL: begin
				pass_q  <= 4'd0;
				r_q     <= r_q >> 1;
				phase_q <= 1'b0;
				i_q     <= 8'(s2);
				j_q     <= 8'(s2);
			end
			S_CELL: begin
				if (i_q >= 8'(GRID_W)) begin
					if (!phase_q) begin
						phase_q <= 1'b1;
						i_q     <= 8'd0;
						par_q   <= 1'b1;
						j_q     <= 8'(s2);
					end else begin
						step_q <= step_q >> 1;
					end
				end else if (j_q >= 8'(GRID_H)) begin
					if (!phase_q) begin
						i_q <= i_q + {1'b0, step_q};
						j_q <= 8'(s2);
					end else begin
						i_q   <= i_q + 8'(s2);
						par_q <= ~par_q;
						j_q   <= par_q ? 8'd0 : 8'(s2);
					end
				end else begin
					acc_q <= 11'd0;
					nb_q  <= 4'd0;
				end
			end
			S_GATHER, S_SM_GATHER: begin
				if (nb_q != 4'd0) acc_q <= acc_q + 11'(grid_rdata);
				nb_q <= nb_q + 4'd1;
			end
			S_PUT: begin
				if (!hrsp.busy) j_q <= j_q + {1'b0, step_q};
			end
			S_SM_PASS: begin
				i_q <= 8'd1;
				j_q <= 8'd1;
			end
			S_SM_CELL: begin
				if (i_q == 8'(GRID_W - 1)) begin
					i_q <= 8'd1;
					j_q <= 8'd1;
				end else if (j_q == 8'(GRID_H - 1)) begin
					i_q <= i_q + 8'd1;
					j_q <= 8'd1;
				end else begin
					acc_q <= 11'd0;
					nb_q  <= 4'd0;
				end
			end
			S_SM_WR: begin
				j_q <= j_q + 8'd1;
			end
			S_COPY_RD: begin
				if (i_q == 8'(GRID_W - 1)) begin
					pass_q <= pass_q + 4'd1;
				end else if (j_q == 8'(GRID_H - 1)) begin
					i_q <= i_q + 8'd1;
					j_q <= 8'd1;
				end
			end
			S_COPY_WR: begin
				j_q <= j_q + 8'd1;
			end
			S_READ_WAIT: begin
				res_q <= grid_rdata;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RESP && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && (!out_valid_q || out_ready)) begin
			height_q <= res_q;
			gdone_q  <= gen_q;
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign height_value  = height_q;
	assign generate_done = gdone_q;

	// hash is only started when idle
	a_hash_start: assert property (@(posedge clk) disable iff (!arst_n)
		hreq.start |-> !hrsp.busy) else $error("hash started while busy");

	// no grid or scratch writes while waiting for a request
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !grid_we && !scr_we) else $error("memory write while idle");

	// a new result only comes from the response state
	a_resp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_RESP) else $error("stray result");

	// a generate result carries a zero height
	a_gen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && gdone_q |-> height_q == 8'd0) else $error("generate height nonzero");

endmodule

### verif/tb_diamond_square_heightmap_top.sv
// tb_diamond_square_heightmap_top: self-checking bench for the height map generator
// drives generate and read requests, predicts every result; needs dsh_pkg and the rtl
`timescale 1ns / 1ps

module tb_diamond_square_heightmap_top import dsh_pkg::*; ;

	localparam int IDLE_LIMIT = 4000000;

	typedef struct {
		logic       kind;
		logic [9:0] seed_offset;
		logic [5:0] col;
		logic [5:0] row;
	} height_req_t;

	typedef struct {
		logic [7:0] height_value;
		logic       generate_done;
	} height_rsp_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       kind;
	logic [9:0] seed_offset;
	logic [5:0] col;
	logic [5:0] row;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] height_value;
	logic       generate_done;
	logic       cfg_write;
	logic [2:0] cfg_index;
	logic [6:0] cfg_data;

	diamond_square_heightmap_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind),
		.seed_offset(seed_offset), .col(col), .row(row),
		.out_valid(out_valid), .out_ready(out_ready),
		.height_value(height_value), .generate_done(generate_done),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// bench state
	height_req_t pending_reqs[$];
	height_rsp_t expected_heights[$];
	int          error_count;
	int          idle_cycles;
	bit          req_taken;
	int          in_gap;
	int          out_gap;

	// predictor state
	logic [7:0] grid_m [CELLS];
	logic [7:0] scratch_m [CELLS];
	logic [9:0] offset_m;
	logic [6:0] step_m;
	logic       randomize_m;
	logic       island_m;
	logic       invert_m;
	logic [3:0] passes_m;

	function automatic logic [31:0] noise_at(int x, int y);
		logic [31:0] n;
		logic [31:0] nn;
		logic [63:0] prod;
		n = 32'(x) + ((32'(offset_m) + 32'(y)) * HASH_ROW_MUL);
		n = (n << 13) ^ n;
		nn = (n * (n * n * HASH_MUL + HASH_ADD0) + HASH_ADD1) & HASH_MASK;
		prod = 64'(nn) * 64'(HASH_SCALE);
		return 32'(prod >> 31);
	endfunction

	function automatic int wrap_low(int v, int half, int size);
		if (v < 0) v = size - half;
		if (v < 0) v = 0;
		return v;
	endfunction

	function automatic int wrap_high(int v, int size);
		return (v >= size) ? 0 : v;
	endfunction

	function automatic int cell_at(int a, int b);
		return int'(grid_m[a * GRID_H + b]);
	endfunction

	function automatic void put_average(int a, int b, int sum, int r);
		int k;
		int t;
		int v;
		k = int'(noise_at(a, b) % 32'(r + 1)) - r / 2;
		t = sum + 4 * k;
		v = (t < 0) ? 0 : (t >>> 2);
		if (v > 255) v = 255;
		grid_m[a * GRID_H + b] = 8'(v);
	endfunction

	// full generate pass on the predictor grid
	function automatic void build_heightmap();
		int step;
		int r;
		int s2;
		int x1;
		int x2;
		int y1;
		int y2;
		int s;
		logic [31:0] v;
		step = (step_m == 0) ? 1 : int'(step_m);
		r = randomize_m ? int'(RANGE_START) : 0;
		for (int c = 0; c < CELLS; c++) grid_m[c] = invert_m ? HEIGHT_MAX : 8'd0;
		// seed lattice
		for (int i = island_m ? step : 0; i < GRID_W; i += step) begin
			for (int j = island_m ? step : 0; j < GRID_H; j += step) begin
				v = noise_at(i, j);
				if (island_m && i == GRID_W / 2 && j == GRID_H / 2) v = 32'(CENTRE_VAL);
				if (invert_m) v = 32'd255 - v;
				grid_m[i * GRID_H + j] = 8'(v);
			end
		end
		// square and diamond levels
		while (step > 1) begin
			r = r / 2;
			s2 = step / 2;
			for (int i = s2; i < GRID_W; i += step) begin
				for (int j = s2; j < GRID_H; j += step) begin
					x1 = wrap_low(i - s2, s2, GRID_W);
					x2 = wrap_high(i + s2, GRID_W);
					y1 = wrap_low(j - s2, s2, GRID_H);
					y2 = wrap_high(j + s2, GRID_H);
					put_average(i, j, cell_at(x1, y1) + cell_at(x2, y1) +
						cell_at(x1, y2) + cell_at(x2, y2), r);
				end
			end
			for (int i = 0; i < GRID_W; i += s2) begin
				for (int j = s2 * ((1 + i / s2) % 2); j < GRID_H; j += step) begin
					x1 = wrap_low(i - s2, s2, GRID_W);
					x2 = wrap_high(i + s2, GRID_W);
					y1 = wrap_low(j - s2, s2, GRID_H);
					y2 = wrap_high(j + s2, GRID_H);
					put_average(i, j, cell_at(i, y1) + cell_at(x1, j) +
						cell_at(i, y2) + cell_at(x2, j), r);
				end
			end
			step = step / 2;
		end
		// 8-neighbour smoothing
		for (int p = 0; p < int'(passes_m); p++) begin
			for (int c = 0; c < CELLS; c++) scratch_m[c] = grid_m[c];
			for (int i = 1; i < GRID_W - 1; i++) begin
				for (int j = 1; j < GRID_H - 1; j++) begin
					s = cell_at(i - 1, j - 1) + cell_at(i - 1, j) + cell_at(i - 1, j + 1) +
						cell_at(i, j - 1) + cell_at(i, j + 1) +
						cell_at(i + 1, j - 1) + cell_at(i + 1, j) + cell_at(i + 1, j + 1);
					scratch_m[i * GRID_H + j] = 8'(s >> 3);
				end
			end
			for (int c = 0; c < CELLS; c++) grid_m[c] = scratch_m[c];
		end
	endfunction

	function automatic height_rsp_t predict_height(height_req_t q);
		height_rsp_t rsp;
		if (q.kind == KIND_GENERATE) begin
			offset_m = q.seed_offset;
			build_heightmap();
			rsp.height_value = 8'd0;
			rsp.generate_done = 1'b1;
		end else begin
			rsp.height_value = grid_m[int'(q.col) * GRID_H + int'(q.row)];
			rsp.generate_done = 1'b0;
		end
		return rsp;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	// request driver, changes on the falling edge
	always @(negedge clk) begin
		logic        next_valid;
		height_req_t q;
		next_valid = in_valid;
		if (!arst_n) begin
			next_valid = 1'b0;
		end else if (!in_valid || req_taken) begin
			req_taken = 1'b0;
			next_valid = 1'b0;
			if (in_gap > 0) begin
				in_gap--;
			end else if (pending_reqs.size() > 0) begin
				q = pending_reqs.pop_front();
				kind <= q.kind;
				seed_offset <= q.seed_offset;
				col <= q.col;
				row <= q.row;
				next_valid = 1'b1;
				in_gap = pick_gap();
			end
		end
		in_valid <= next_valid;
	end

	// result sink stalls, changes on the falling edge
	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 2) == 0) out_gap = pick_gap();
		end
	end

	// monitor: accept requests, check results, watchdog
	always @(posedge clk) begin
		height_req_t q;
		height_rsp_t want;
		bit          moved;
		moved = 1'b0;
		if (arst_n && in_valid && in_ready) begin
			q.kind = kind;
			q.seed_offset = seed_offset;
			q.col = col;
			q.row = row;
			expected_heights.push_back(predict_height(q));
			req_taken = 1'b1;
			moved = 1'b1;
		end
		if (arst_n && out_valid && out_ready) begin
			moved = 1'b1;
			if (expected_heights.size() == 0) begin
				report_mismatch("unexpected result", int'(height_value), -1);
			end else begin
				want = expected_heights.pop_front();
				if (height_value !== want.height_value)
					report_mismatch("height_value", int'(height_value), int'(want.height_value));
				if (generate_done !== want.generate_done)
					report_mismatch("generate_done", int'(generate_done),
						int'(want.generate_done));
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// register write, model updated alongside
	task automatic write_reg(logic [2:0] index, logic [6:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		case (index)
			REG_INITIAL_STEP:  step_m = value;
			REG_RANDOMIZE:     randomize_m = value[0];
			REG_ISLAND:        island_m = value[0];
			REG_INVERT:        invert_m = value[0];
			REG_SMOOTH_PASSES: passes_m = value[3:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(int step, int rnd, int isl, int inv, int passes);
		write_reg(REG_INITIAL_STEP, 7'(step));
		write_reg(REG_RANDOMIZE, 7'(rnd));
		write_reg(REG_ISLAND, 7'(isl));
		write_reg(REG_INVERT, 7'(inv));
		write_reg(REG_SMOOTH_PASSES, 7'(passes));
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic queue_generate(int offset);
		height_req_t q;
		q.kind = KIND_GENERATE;
		q.seed_offset = 10'(offset);
		q.col = 6'($urandom);
		q.row = 6'($urandom);
		pending_reqs.push_back(q);
	endtask

	task automatic queue_read(int c, int r);
		height_req_t q;
		q.kind = KIND_READ;
		q.seed_offset = 10'($urandom_range(0, 999));
		q.col = 6'(c);
		q.row = 6'(r);
		pending_reqs.push_back(q);
	endtask

	// hold the sender off until every result is back
	task automatic drain_all();
		while (pending_reqs.size() > 0 || in_valid || expected_heights.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// stimulus
	initial begin
		error_count = 0;
		idle_cycles = 0;
		req_taken = 1'b0;
		in_gap = 0;
		out_gap = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_GENERATE;
		seed_offset = '0;
		col = '0;
		row = '0;
		out_ready = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		offset_m = '0;
		step_m = 7'd16;
		randomize_m = 1'b1;
		island_m = 1'b0;
		invert_m = 1'b0;
		passes_m = 4'd6;
		for (int c = 0; c < CELLS; c++) grid_m[c] = 8'd0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings, largest offset, corner reads
		queue_generate(999);
		queue_read(0, 0);
		queue_read(63, 63);
		queue_read(0, 63);
		queue_read(63, 0);
		queue_read(32, 32);
		queue_read(42, 21);
		queue_read(21, 42);
		drain_all();

		// zero step, no displacement, island, inverted, no smoothing
		apply_setting(0, 0, 1, 1, 0);
		queue_generate(512);
		queue_read(32, 32);
		queue_read(0, 0);
		queue_read(1, 62);
		queue_read(63, 31);
		queue_read(17, 5);
		drain_all();

		// widest step, most smoothing passes, offset zero
		apply_setting(64, 1, 0, 0, 15);
		queue_generate(0);
		queue_read(0, 0);
		queue_read(1, 1);
		queue_read(62, 62);
		queue_read(63, 1);
		queue_read(32, 33);
		drain_all();

		// random settings, one generate then random reads
		for (int round = 0; round < 3; round++) begin
			apply_setting($urandom_range(0, 64), $urandom_range(0, 1), $urandom_range(0, 1),
				$urandom_range(0, 1), $urandom_range(0, 2));
			queue_generate($urandom_range(0, 999));
			for (int n = 0; n < 30; n++) queue_read($urandom_range(0, 63), $urandom_range(0, 63));
			drain_all();
		end

		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
